// ===== rtl/mbb_pkg.sv =====
// Shared types and constants for the box-filter mipmap builder.
// No dependencies; every other file in rtl/ imports this package.
package mbb_pkg;

   localparam int LVL_W        = 4;   // level and per-axis log2 values
   localparam int ADDR_FIELD_W = 14;  // byte address field of a request
   localparam int VALUE_W      = 8;   // one stored byte
   localparam int CFG_W        = 3;   // widest configuration register
   localparam int CSR_IDX_W    = 2;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int CH_CNT_W     = 2;   // channel counter, at most four channels
   localparam int ACC_W        = 10;  // sum of four bytes

   localparam int DEF_MAX_SIDE_LOG2 = 6;
   localparam int DEF_MAX_CHANNELS  = 4;

   localparam logic [CFG_W-1:0] RST_WIDTH_LOG2  = 3'd6;
   localparam logic [CFG_W-1:0] RST_HEIGHT_LOG2 = 3'd6;
   localparam logic [CFG_W-1:0] RST_CHANNELS    = 3'd4;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_REDUCE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_REFUSED = 2'd1,
      STAT_RANGE   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH_LOG2  = 2'd0,
      CSR_HEIGHT_LOG2 = 2'd1,
      CSR_CHANNELS    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MB_IDLE,
      MB_GATHER,
      MB_STORE
   } state_type;

endpackage

// ===== rtl/mbb_if.sv =====
// Valid/ready channel interfaces of the mipmap builder: request and response.
// Depends on mbb_pkg for field widths.
interface mbb_req_if import mbb_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [ADDR_FIELD_W-1:0] address;
   logic [VALUE_W-1:0]      value;

   modport source (output valid, output op, output address, output value, input ready);
   modport sink   (input valid, input op, input address, input value, output ready);
endinterface

interface mbb_rsp_if import mbb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic [LVL_W-1:0]    level;
   logic                is_smallest;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output read_value, output level, output is_smallest,
                   output status, input ready);
   modport sink   (input valid, input read_value, input level, input is_smallest,
                   input status, output ready);
endinterface

// ===== rtl/mbb_ram.sv =====
// Generic single-port RAM with registered read data.
// Read data updates only on a read cycle and holds otherwise. Uses mbb_pkg.
module mbb_ram import mbb_pkg::*; #(
   parameter int WIDTH = VALUE_W,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/box_filter_mipmap_builder.sv =====
// Box-filter mipmap builder: byte store, reduce sequencer and response stages.
// Depends on mbb_pkg, mbb_req_if / mbb_rsp_if and mbb_ram.
//
// Usage:
//   Requests arrive on req_ch (op, address, value); each gives exactly one
//   response on rsp_ch (read_value, level, is_smallest, status), in order.
//   Write loads a level-0 byte and returns the chain to level 0; read returns
//   a byte of the current level; reduce builds the next level in place.
//   csr_* writes width_log2, height_log2 and channels; write them only while
//   no request is outstanding.
// Timing:
//   Write, read and unused ops can be issued every cycle while rsp_ch.ready
//   stays high; the response is registered in p1 and then in the output register.
//   A reduce walks every destination byte of the new level through the single
//   store port: four source reads and one write per byte, then its response
//   goes through p1 and the output register. req_ch.ready stays low during the walk.
//   A reduce refused at 1x1 answers like a write or read.
// Reset: level returns to 0 and the registers to 6, 6 and 4; store contents
//   are undefined until written.
// Stall: a response waits in the output register while rsp_ch.ready is low;
//   one more request is taken behind it, then req_ch.ready drops.
module box_filter_mipmap_builder import mbb_pkg::*; #(
   parameter int MAX_SIDE_LOG2 = DEF_MAX_SIDE_LOG2,
   parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   mbb_req_if.sink              req_ch,
   mbb_rsp_if.source            rsp_ch
);

   localparam int STORE_DEPTH = (1 << (2 * MAX_SIDE_LOG2)) * MAX_CHANNELS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = MAX_SIDE_LOG2;
   localparam int PIX_W       = 2 * MAX_SIDE_LOG2;
   localparam int SCL_W       = PIX_W + 3;
   localparam int SZ_W        = 2 * MAX_SIDE_LOG2 + 3;
   localparam int CMP_W       = SZ_W + ADDR_FIELD_W;
   localparam int WIDE_W      = ADDR_W + ADDR_FIELD_W;
   localparam logic [LVL_W-1:0] MAX_LOG = LVL_W'(MAX_SIDE_LOG2);
   localparam logic [CFG_W-1:0] MAX_CC  = CFG_W'(MAX_CHANNELS);

   typedef struct packed {
      logic                rd;
      logic [LVL_W-1:0]    level;
      logic                smallest;
      logic [STATUS_W-1:0] status;
   } meta_type;

   // configuration and control state
   logic [CFG_W-1:0] wlog_ff, hlog_ff, chan_ff;
   logic [LVL_W-1:0] level_ff, level_in;
   state_type        state_ff, state_in;
   logic [1:0]       k_ff, k_in;
   logic [CH_CNT_W-1:0] z_ff, z_in;
   logic [CNT_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             p1_valid_ff, rsp_valid_ff;
   meta_type         p1_ff, p1_in, rsp_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic             p1_load, adv, p1_free, req_ready, accept;
   logic             ram_en, ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [VALUE_W-1:0] ram_wdata, ram_rdata;

   logic [LVL_W-1:0] wl_eff, hl_eff, wl_cur, hl_cur, wl_nxt, hl_nxt, nwl, nhl;
   logic [CFG_W-1:0] cc_eff;
   logic             small_now, small_lvl0, small_after, wr_ok, rd_ok;
   logic [CNT_W:0]   sx_w, sy_w;
   logic [CNT_W-1:0] sx, sy, x_mask, y_mask;
   logic [PIX_W-1:0] src_pix, dst_pix;
   logic [SCL_W-1:0] src_scl, dst_scl;
   logic [WIDE_W-1:0] req_addr_wide;
   logic             x_last, y_last, z_last;
   logic [ACC_W-1:0] sum_w;

   function automatic logic [LVL_W-1:0] axis_f(input logic [LVL_W-1:0] lg,
                                                input logic [LVL_W-1:0] lvl);
      return (lvl >= lg) ? '0 : lg - lvl;
   endfunction

   function automatic logic [SZ_W-1:0] size_f(input logic [LVL_W-1:0] wl,
                                              input logic [LVL_W-1:0] hl,
                                              input logic [CFG_W-1:0] cc);
      logic [LVL_W:0] sh;
      sh = {1'b0, wl} + {1'b0, hl};
      return SZ_W'(cc) << sh;
   endfunction

   // pixel index times channel count plus channel, channel count is 1 to 4
   function automatic logic [SCL_W-1:0] scale_f(input logic [PIX_W-1:0] pix,
                                               input logic [CFG_W-1:0] cc,
                                               input logic [CH_CNT_W-1:0] z);
      logic [SCL_W-1:0] p;
      logic [SCL_W-1:0] s;
      p = SCL_W'(pix);
      case (cc)
         3'd2:    s = p << 1;
         3'd3:    s = (p << 1) + p;
         3'd4:    s = p << 2;
         default: s = p;
      endcase
      return s + SCL_W'(z);
   endfunction

   // effective geometry from the registers as they stand
   always_comb begin
      wl_eff = (LVL_W'(wlog_ff) > MAX_LOG) ? MAX_LOG : LVL_W'(wlog_ff);
      hl_eff = (LVL_W'(hlog_ff) > MAX_LOG) ? MAX_LOG : LVL_W'(hlog_ff);
      if (chan_ff == '0) begin
         cc_eff = CFG_W'(1);
      end else begin
         cc_eff = (chan_ff > MAX_CC) ? MAX_CC : chan_ff;
      end
      wl_cur      = axis_f(wl_eff, level_ff);
      hl_cur      = axis_f(hl_eff, level_ff);
      wl_nxt      = axis_f(wl_eff, level_ff + LVL_W'(1));
      hl_nxt      = axis_f(hl_eff, level_ff + LVL_W'(1));
      small_now   = (wl_cur == '0) && (hl_cur == '0);
      small_after = (wl_nxt == '0) && (hl_nxt == '0);
      small_lvl0  = (wl_eff == '0) && (hl_eff == '0);
      nwl = (wl_cur != '0) ? wl_cur - LVL_W'(1) : '0;
      nhl = (hl_cur != '0) ? hl_cur - LVL_W'(1) : '0;

      req_addr_wide = WIDE_W'(req_ch.address);
      wr_ok = CMP_W'(req_ch.address) < CMP_W'(size_f(wl_eff, hl_eff, cc_eff));
      rd_ok = CMP_W'(req_ch.address) < CMP_W'(size_f(wl_cur, hl_cur, cc_eff));

      // source pixel of the 2x2 block: k[0] picks the column, k[1] the row
      sx_w = {x_ff, k_ff[0]};
      sy_w = {y_ff, k_ff[1]};
      sx   = (wl_cur != '0) ? sx_w[CNT_W-1:0] : '0;
      sy   = (hl_cur != '0) ? sy_w[CNT_W-1:0] : '0;
      src_pix = (PIX_W'(sy) << wl_cur) | PIX_W'(sx);
      dst_pix = (PIX_W'(y_ff) << nwl) | PIX_W'(x_ff);
      src_scl = scale_f(src_pix, cc_eff, z_ff);
      dst_scl = scale_f(dst_pix, cc_eff, z_ff);

      x_mask = ~({CNT_W{1'b1}} << nwl);
      y_mask = ~({CNT_W{1'b1}} << nhl);
      x_last = (x_ff == x_mask);
      y_last = (y_ff == y_mask);
      z_last = ({1'b0, z_ff} == (cc_eff - CFG_W'(1)));
      sum_w  = acc_ff + ACC_W'(ram_rdata);
   end

   assign adv       = !rsp_valid_ff || rsp_ch.ready;
   assign p1_free   = !p1_valid_ff || adv;
   assign req_ready = (state_ff == MB_IDLE) && p1_free;
   assign accept    = req_ch.valid && req_ready;

   // sequencer: next state, store port and counters
   always_comb begin
      state_in  = state_ff;
      level_in  = level_ff;
      k_in      = k_ff;
      z_in      = z_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      p1_load   = 1'b0;
      p1_in     = '{rd: 1'b0, level: level_ff, smallest: small_now, status: STAT_OK};
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = req_addr_wide[ADDR_W-1:0];
      ram_wdata = req_ch.value;

      unique case (state_ff)
         MB_IDLE: begin
            if (accept) begin
               p1_load = 1'b1;
               case (req_ch.op)
                  OP_WRITE: begin
                     level_in       = '0;
                     p1_in.level    = '0;
                     p1_in.smallest = small_lvl0;
                     p1_in.status   = wr_ok ? STAT_OK : STAT_RANGE;
                     ram_en         = wr_ok;
                     ram_we         = 1'b1;
                  end
                  OP_REDUCE: begin
                     if (small_now) begin
                        p1_in.status = STAT_REFUSED;
                     end else begin
                        p1_load  = 1'b0;
                        state_in = MB_GATHER;
                        k_in     = '0;
                        z_in     = '0;
                        x_in     = '0;
                        y_in     = '0;
                     end
                  end
                  OP_READ: begin
                     p1_in.rd     = rd_ok;
                     p1_in.status = rd_ok ? STAT_OK : STAT_RANGE;
                     ram_en       = rd_ok;
                  end
                  default: begin
                  end
               endcase
            end
         end
         MB_GATHER: begin
            // read source k, fold in the byte that the previous read returned (none at k 0)
            ram_en   = 1'b1;
            ram_addr = src_scl[ADDR_W-1:0];
            acc_in   = (k_ff == 2'd0) ? '0 : sum_w;
            k_in     = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = MB_STORE;
            end
         end
         MB_STORE: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = dst_scl[ADDR_W-1:0];
            ram_wdata = sum_w[ACC_W-1:2];
            state_in  = MB_GATHER;
            if (!z_last) begin
               z_in = z_ff + CH_CNT_W'(1);
            end else begin
               z_in = '0;
               if (!x_last) begin
                  x_in = x_ff + CNT_W'(1);
               end else begin
                  x_in = '0;
                  y_in = y_ff + CNT_W'(1);
                  if (y_last) begin
                     state_in       = MB_IDLE;
                     level_in       = level_ff + LVL_W'(1);
                     p1_load        = 1'b1;
                     p1_in.level    = level_ff + LVL_W'(1);
                     p1_in.smallest = small_after;
                  end
               end
            end
         end
         default: begin
            state_in = MB_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlog_ff      <= RST_WIDTH_LOG2;
         hlog_ff      <= RST_HEIGHT_LOG2;
         chan_ff      <= RST_CHANNELS;
         level_ff     <= '0;
         state_ff     <= MB_IDLE;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WIDTH_LOG2:  wlog_ff <= csr_write_data;
               CSR_HEIGHT_LOG2: hlog_ff <= csr_write_data;
               CSR_CHANNELS:    chan_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         level_ff <= level_in;
         state_ff <= state_in;
         if (p1_load) begin
            p1_valid_ff <= 1'b1;
         end else if (adv) begin
            p1_valid_ff <= 1'b0;
         end
         if (adv) begin
            rsp_valid_ff <= p1_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      z_ff   <= z_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      if (p1_load) begin
         p1_ff <= p1_in;
      end
      // store read data belongs to the item in p1 at this edge
      if (adv && p1_valid_ff) begin
         rsp_ff       <= p1_ff;
         rsp_value_ff <= p1_ff.rd ? ram_rdata : '0;
      end
   end

   mbb_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.level       = rsp_ff.level;
   assign rsp_ch.is_smallest = rsp_ff.smallest;
   assign rsp_ch.status      = rsp_ff.status;

   // the store port belongs to the sequencer while a reduce runs
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != MB_IDLE) |-> !p1_valid_ff)
      else $error("response stage busy during reduce");

   assert property (@(posedge clock) disable iff (reset)
      level_ff <= MAX_LOG)
      else $error("level beyond largest side");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.op == OP_WRITE)) |=> (level_ff == '0))
      else $error("write did not return to level 0");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.op == OP_REDUCE) && !small_now) |=>
         ((state_ff == MB_GATHER) && (k_ff == 2'd0)))
      else $error("reduce did not start its walk");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == MB_STORE) |=> ((state_ff == MB_IDLE) || (k_ff == 2'd0)))
      else $error("gather count out of step");

endmodule
